@@ rtl/brb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Types, constants and helpers shared by the byte ring buffer modules.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = IDX_W + 1;

  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_PEEK  = 3'd2;
  localparam logic [2:0] MODE_SKIP  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic [9:0] peek_offset;
    logic [9:0] skip_count;
  } brb_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        done_res;
    logic [9:0]  used_bytes;
    logic [9:0]  free_bytes;
    logic [10:0] contiguous_free;
    logic [9:0]  contiguous_used;
  } brb_rsp_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } brb_mem_cmd_t;

  typedef struct packed {
    logic        rd_sel;
    logic        done_res;
    logic [9:0]  used_bytes;
    logic [9:0]  free_bytes;
    logic [10:0] contiguous_free;
    logic [9:0]  contiguous_used;
  } brb_stat_t;

  // index plus step, wrapped by one compare and subtract
  function automatic logic [IDX_W-1:0] wrap_add(input logic [CAP_W-1:0] idx,
                                                input logic [CAP_W-1:0] n,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] s;
    s = {1'b0, idx} + {1'b0, n};
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] held(input logic [IDX_W-1:0] w,
                                            input logic [IDX_W-1:0] r,
                                            input logic [CAP_W-1:0] cap);
    if (w >= r) begin
      return {1'b0, w} - {1'b0, r};
    end
    return cap - {1'b0, r} + {1'b0, w};
  endfunction

endpackage

@@ rtl/brb_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module brb_mem
  import brb_pkg::*;
(
  input  logic         clk,
  input  brb_mem_cmd_t cmd,
  output logic [7:0]   rd_data
);

  logic [7:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= store[cmd.rd_addr];
    end
  end

endmodule

@@ rtl/brb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Index update, fill status and result register for the byte ring buffer.
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  brb_req_t     req_word,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output brb_stat_t    stat,
  input  logic         cfg_we,
  input  logic [10:0]  cfg_data,
  output brb_mem_cmd_t cmd
);

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] used_now, free_now, cnt, used_after;
  logic [CAP_W-1:0] cap_next;
  logic             accept;
  logic             done, rd_sel;
  brb_stat_t        stat_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    if (cfg_data < 11'd2) begin
      cap_next = CAP_W'(2);
    end else if (cfg_data > 11'(DEPTH)) begin
      cap_next = CAP_W'(DEPTH);
    end else begin
      cap_next = CAP_W'(cfg_data);
    end
  end

  always_comb begin
    used_now         = held(write_index, read_index, capacity);
    free_now         = capacity - used_now - CAP_W'(1);
    write_index_next = write_index;
    read_index_next  = read_index;
    done             = 1'b0;
    rd_sel           = 1'b0;
    cnt              = CAP_W'(req_word.skip_count);
    cmd.wr_en        = 1'b0;
    cmd.wr_addr      = write_index;
    cmd.wr_data      = req_word.data_byte;
    cmd.rd_en        = 1'b0;
    cmd.rd_addr      = read_index;
    case (req_word.mode)
      MODE_PUSH: begin
        if (free_now != '0) begin
          cmd.wr_en        = accept;
          write_index_next = wrap_add({1'b0, write_index}, CAP_W'(1), capacity);
          done             = 1'b1;
        end
      end
      MODE_POP: begin
        if (used_now != '0) begin
          cmd.rd_en       = accept;
          rd_sel          = 1'b1;
          read_index_next = wrap_add({1'b0, read_index}, CAP_W'(1), capacity);
          done            = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (used_now > CAP_W'(req_word.peek_offset)) begin
          cmd.rd_en   = accept;
          cmd.rd_addr = wrap_add({1'b0, read_index}, CAP_W'(req_word.peek_offset),
                                 capacity);
          rd_sel      = 1'b1;
          done        = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (cnt > used_now) begin
          cnt  = used_now;
          done = 1'b0;
        end else begin
          done = 1'b1;
        end
        read_index_next = wrap_add({1'b0, read_index}, cnt, capacity);
      end
      MODE_CLEAR: begin
        write_index_next = '0;
        read_index_next  = '0;
        done             = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase

    used_after           = held(write_index_next, read_index_next, capacity);
    stat_next.rd_sel     = rd_sel;
    stat_next.done_res   = done;
    stat_next.used_bytes = used_after[9:0];
    stat_next.free_bytes = 10'(capacity - used_after - CAP_W'(1));
    if (write_index_next >= read_index_next) begin
      stat_next.contiguous_free = 11'(capacity - {1'b0, write_index_next});
      stat_next.contiguous_used = 10'(write_index_next - read_index_next);
    end else begin
      stat_next.contiguous_free = 11'(read_index_next - write_index_next - IDX_W'(1));
      stat_next.contiguous_used = 10'(capacity - {1'b0, read_index_next});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      capacity    <= CAP_W'(DEPTH);
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity    <= cap_next;
        write_index <= '0;
        read_index  <= '0;
      end else if (accept) begin
        write_index <= write_index_next;
        read_index  <= read_index_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
    end
  end

endmodule

@@ rtl/byte_ring_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO with push, pop, peek, skip and clear, one slot kept empty.
//
//   channel | handshake           | word
//   req     | req_valid/req_stall | brb_req_t
//   rsp     | rsp_valid/rsp_stall | brb_rsp_t
//   cfg     | cfg_we              | cfg_data (capacity in use)
//
// one operation per cycle while req_stall is low; its result appears in the cycle after acceptance.
// byte store has one write and one registered read port; a push and a later
// pop or peek never touch the same entry in the same cycle.
// rst clears indices and sets capacity to the full depth; store is not cleared.
// req_stall is high while a result is held under rsp_stall.
// ----------------------------------------------------------------------------
module byte_ring_buffer
  import brb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  brb_req_t    req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output brb_rsp_t    rsp_word,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data
);

  brb_mem_cmd_t cmd;
  brb_stat_t    stat;
  logic [7:0]   rd_data;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd)
  );

  brb_mem u_mem (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  always_comb begin
    rsp_word.read_byte       = stat.rd_sel ? rd_data : 8'd0;
    rsp_word.done_res        = stat.done_res;
    rsp_word.used_bytes      = stat.used_bytes;
    rsp_word.free_bytes      = stat.free_bytes;
    rsp_word.contiguous_free = stat.contiguous_free;
    rsp_word.contiguous_used = stat.contiguous_used;
  end

endmodule

@@ rtl/brb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks for the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module brb_checker
  import brb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input brb_rsp_t    rsp_word
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("result word changed while stalled");

  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted word gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled with output free");

  a_fill_sum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, rsp_word.used_bytes} + {1'b0, rsp_word.free_bytes}) < 11'(DEPTH))
    else $error("used plus free exceeds capacity");

  a_byte_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.read_byte != 8'd0 |-> rsp_word.done_res)
    else $error("byte returned on refused operation");

endmodule

bind byte_ring_buffer brb_checker u_chk (.*);

@@ tb/byte_ring_buffer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_tb
// Self-checking testbench for the byte ring buffer. A shadow ring with its
// own indices, capacity and byte store predicts the status word of every
// accepted operation. A monitor compares each result word, field by field,
// against the oldest prediction. Directed operations cover the empty, full
// and clamp cases and the capacity limits. Random traffic then runs under
// several idle and stall mixes with capacity changes between segments. A
// long receiver hold-off keeps a result held and so stalls the block's input.
// ----------------------------------------------------------------------------
module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int SEGMENT_ITEMS  = 65;
  localparam int PHASE_ITEMS    = 272;
  localparam int PRESSURE_ITEMS = 40;

  localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  brb_req_t    req_word = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  brb_rsp_t    rsp_word;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;

  // shadow ring
  logic [7:0] shadow_mem [0:DEPTH-1];
  int ring_cap = DEPTH;
  int ring_wr  = 0;
  int ring_rd  = 0;

  brb_rsp_t expected_rsp [$];
  brb_rsp_t want_rsp;
  int error_count   = 0;
  int req_idle_pct  = 0;
  int rsp_stall_pct = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  byte_ring_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int ring_fill();
    if (ring_wr >= ring_rd) begin
      return ring_wr - ring_rd;
    end
    return ring_cap - ring_rd + ring_wr;
  endfunction

  function automatic int ring_advance(input int idx, input int n);
    int s;
    s = idx + n;
    if (s >= ring_cap) begin
      s = s - ring_cap;
    end
    return s;
  endfunction

  function automatic brb_rsp_t predict_op(input brb_req_t w);
    brb_rsp_t r;
    int fill;
    int cnt;
    r = '0;
    fill = ring_fill();
    case (w.mode)
      MODE_PUSH: begin
        if (ring_cap - fill - 1 != 0) begin
          shadow_mem[ring_wr] = w.data_byte;
          ring_wr = ring_advance(ring_wr, 1);
          r.done_res = 1'b1;
        end
      end
      MODE_POP: begin
        if (fill != 0) begin
          r.read_byte = shadow_mem[ring_rd];
          ring_rd = ring_advance(ring_rd, 1);
          r.done_res = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (fill > int'(w.peek_offset)) begin
          r.read_byte = shadow_mem[ring_advance(ring_rd, int'(w.peek_offset))];
          r.done_res = 1'b1;
        end
      end
      MODE_SKIP: begin
        cnt = int'(w.skip_count);
        if (cnt > fill) begin
          cnt = fill;
        end else begin
          r.done_res = 1'b1;
        end
        ring_rd = ring_advance(ring_rd, cnt);
      end
      MODE_CLEAR: begin
        ring_wr = 0;
        ring_rd = 0;
        r.done_res = 1'b1;
      end
      default: begin
      end
    endcase
    fill = ring_fill();
    r.used_bytes = 10'(fill);
    r.free_bytes = 10'(ring_cap - fill - 1);
    if (ring_wr >= ring_rd) begin
      r.contiguous_free = 11'(ring_cap - ring_wr);
      r.contiguous_used = 10'(ring_wr - ring_rd);
    end else begin
      r.contiguous_free = 11'(ring_rd - ring_wr - 1);
      r.contiguous_used = 10'(ring_cap - ring_rd);
    end
    return r;
  endfunction

  function automatic brb_req_t make_word(input logic [2:0] mode, input logic [7:0] data,
                                         input logic [9:0] offset, input logic [9:0] count);
    brb_req_t w;
    w.mode = mode;
    w.data_byte = data;
    w.peek_offset = offset;
    w.skip_count = count;
    return w;
  endfunction

  function automatic brb_req_t random_word(input int push_pct);
    brb_req_t w;
    int roll;
    int fill;
    fill = ring_fill();
    w.data_byte = 8'($urandom);
    w.peek_offset = 10'($urandom);
    w.skip_count = 10'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      w.mode = MODE_PUSH;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        w.mode = MODE_POP;
      end else if (roll < 65) begin
        w.mode = MODE_PEEK;
      end else if (roll < 88) begin
        w.mode = MODE_SKIP;
      end else if (roll < 95) begin
        w.mode = MODE_CLEAR;
      end else begin
        w.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
      end
    end
    // mostly in-range offsets and counts, with an edge case now and then
    if (w.mode == MODE_PEEK && $urandom_range(0, 99) < 80) begin
      w.peek_offset = 10'($urandom_range(0, fill));
    end
    if (w.mode == MODE_SKIP && $urandom_range(0, 99) < 70) begin
      w.skip_count = 10'($urandom_range(0, (fill < 1023) ? fill + 1 : 1023));
    end
    return w;
  endfunction

  function automatic logic [10:0] pick_capacity();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd2047;
      3: return 11'd1024;
      4: return 11'($urandom_range(1025, 2047));
      5: return 11'($urandom_range(17, 1023));
      default: return 11'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic send_word(input brb_req_t w);
    if ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < req_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp.push_back(predict_op(w));
  endtask

  task automatic write_capacity(input logic [10:0] value);
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value < 11'd2) begin
      ring_cap = 2;
    end else if (value > 11'(DEPTH)) begin
      ring_cap = DEPTH;
    end else begin
      ring_cap = int'(value);
    end
    ring_wr = 0;
    ring_rd = 0;
  endtask

  task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic test_directed_ops();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    send_word(make_word(MODE_POP, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_PEEK, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_SKIP, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_SKIP, 8'h00, 10'd0, 10'd1023));
    send_word(make_word(MODE_PUSH, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_PUSH, 8'hFF, 10'd0, 10'd0));
    send_word(make_word(MODE_PEEK, 8'h00, 10'd1, 10'd0));
    send_word(make_word(MODE_PEEK, 8'h00, 10'd1023, 10'd0));
    send_word(make_word(MODE_POP, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_SKIP, 8'h00, 10'd0, 10'd1));
    send_word(make_word(MODE_CLEAR, 8'h00, 10'd0, 10'd0));
    for (int m = MODE_RSVD_FIRST; m <= MODE_RSVD_LAST; m++) begin
      send_word(make_word(3'(m), 8'hFF, 10'd1023, 10'd1023));
    end
  endtask

  task automatic test_capacity_extremes();
    // below the minimum, taken as two slots
    write_capacity(11'd0);
    send_word(make_word(MODE_PUSH, 8'h11, 10'd0, 10'd0));
    send_word(make_word(MODE_PUSH, 8'h22, 10'd0, 10'd0));
    send_word(make_word(MODE_POP, 8'h00, 10'd0, 10'd0));
    send_word(make_word(MODE_PUSH, 8'h33, 10'd0, 10'd0));
    write_capacity(11'd1);
    write_capacity(11'd2047);
    send_word(make_word(MODE_PUSH, 8'h44, 10'd0, 10'd0));
    write_capacity(11'd3);
    send_word(make_word(MODE_PUSH, 8'h55, 10'd0, 10'd0));
    send_word(make_word(MODE_PUSH, 8'h66, 10'd0, 10'd0));
    send_word(make_word(MODE_PUSH, 8'h77, 10'd0, 10'd0));
    send_word(make_word(MODE_SKIP, 8'h00, 10'd0, 10'd1023));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int push_pct;
    push_pct = 50;
    req_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % SEGMENT_ITEMS == 0) begin
        write_capacity(pick_capacity());
        push_pct = $urandom_range(30, 70);
      end
      send_word(random_word(push_pct));
    end
  endtask

  task automatic test_backpressure();
    req_idle_pct = 0;
    rsp_stall_pct = 0;
    write_capacity(11'd64);
    hold_token = hold_token + 1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      send_word(random_word(60));
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (expected_rsp.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none actual %h", $time, rsp_word);
      end else begin
        want_rsp = expected_rsp.pop_front();
        check_field("read_byte", 11'(want_rsp.read_byte), 11'(rsp_word.read_byte));
        check_field("done_res", 11'(want_rsp.done_res), 11'(rsp_word.done_res));
        check_field("used_bytes", 11'(want_rsp.used_bytes), 11'(rsp_word.used_bytes));
        check_field("free_bytes", 11'(want_rsp.free_bytes), 11'(rsp_word.free_bytes));
        check_field("contiguous_free", want_rsp.contiguous_free, rsp_word.contiguous_free);
        check_field("contiguous_used", 11'(want_rsp.contiguous_used),
                    11'(rsp_word.contiguous_used));
      end
    end
  end

  // watchdog on cycles without any accepted word, taken result or capacity write
  always @(posedge clk) begin
    if (rst || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_mem[i] = 8'h00;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_capacity_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(77, 0);
    test_random_traffic(0, 77);
    test_random_traffic(22, 22);
    test_backpressure();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
